@@ sv/llwa_pkg.sv @@
// llwa_pkg: shared types and constants for the least-loaded worker assigner.
// No dependencies.
`default_nettype none
package llwa_pkg;

   localparam int TIME_W  = 63;
   localparam int DUR_W   = 32;
   localparam int OIDX_W  = 6;
   localparam int CSR_W   = 7;
   localparam int CSR_RST = 64;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_ADD
   } llwa_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } llwa_mem_ctl_type;

   typedef struct packed {
      llwa_state_type state;
      logic           res_load;
   } llwa_stat_type;

endpackage
`default_nettype wire

@@ sv/llwa_time_mem.sv @@
// llwa_time_mem: free-time memory, one write and one read port, registered read.
// Depends on llwa_pkg.
`default_nettype none
module llwa_time_mem #(
   parameter  int MAX_WORKERS = 64,
   localparam int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1
) (
   input  wire                          clock,
   input  llwa_pkg::llwa_mem_ctl_type   mem_ctl,
   input  wire [IDX_W-1:0]              wr_addr,
   input  wire [llwa_pkg::TIME_W-1:0]   wr_data,
   input  wire [IDX_W-1:0]              rd_addr,
   output logic [llwa_pkg::TIME_W-1:0]  rd_data
);

   logic [llwa_pkg::TIME_W-1:0] time_mem_ff [MAX_WORKERS];
   logic [llwa_pkg::TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         time_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= time_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/llwa_ctrl.sv @@
// llwa_ctrl: clearing pass, minimum scan over the free-time memory and
// saturating update. Depends on llwa_pkg.
`default_nettype none
module llwa_ctrl #(
   parameter  int MAX_WORKERS = 64,
   localparam int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
   localparam int CNT_W       = $clog2(MAX_WORKERS + 1)
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [llwa_pkg::DUR_W-1:0]    req_dur,
   input  wire [CNT_W-1:0]              active_cnt,
   input  wire                          out_free,
   output llwa_pkg::llwa_mem_ctl_type   mem_ctl,
   output logic [IDX_W-1:0]             mem_waddr,
   output logic [llwa_pkg::TIME_W-1:0]  mem_wdata,
   output logic [IDX_W-1:0]             mem_raddr,
   input  wire [llwa_pkg::TIME_W-1:0]   mem_rdata,
   output llwa_pkg::llwa_stat_type      stat,
   output logic [IDX_W-1:0]             res_idx,
   output logic [llwa_pkg::TIME_W-1:0]  res_start
);

   llwa_pkg::llwa_state_type     state_ff, state_in;
   logic [CNT_W-1:0]             iss_ff, iss_in;
   logic [IDX_W-1:0]             dat_ff, dat_in;
   logic [llwa_pkg::TIME_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic [llwa_pkg::DUR_W-1:0]   dur_ff, dur_in;
   logic [llwa_pkg::TIME_W:0]    sum;
   logic [llwa_pkg::TIME_W-1:0]  sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= llwa_pkg::ST_CLEAR;
         iss_ff   <= '0;
      end else begin
         state_ff <= state_in;
         iss_ff   <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      dat_ff      <= dat_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      dur_ff      <= dur_in;
   end

   assign sum = {1'b0, best_ff} + {{(llwa_pkg::TIME_W + 1 - llwa_pkg::DUR_W){1'b0}}, dur_ff};
   assign sat = sum[llwa_pkg::TIME_W] ? llwa_pkg::TIME_MAX : sum[llwa_pkg::TIME_W-1:0];

   always_comb begin
      state_in      = state_ff;
      iss_in        = iss_ff;
      dat_in        = dat_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      dur_in        = dur_ff;
      req_ready     = 1'b0;
      mem_ctl.rd_en = 1'b0;
      mem_ctl.wr_en = 1'b0;
      mem_waddr     = best_idx_ff;
      mem_wdata     = sat;
      mem_raddr     = iss_ff[IDX_W-1:0];
      stat.state    = state_ff;
      stat.res_load = 1'b0;
      case (state_ff)
         llwa_pkg::ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_waddr     = iss_ff[IDX_W-1:0];
            mem_wdata     = '0;
            iss_in        = iss_ff + CNT_W'(1);
            if (iss_ff == CNT_W'(MAX_WORKERS - 1)) begin
               iss_in   = '0;
               state_in = llwa_pkg::ST_IDLE;
            end
         end
         llwa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dur_in        = req_dur;
               mem_ctl.rd_en = 1'b1;
               mem_raddr     = '0;
               iss_in        = CNT_W'(1);
               dat_in        = '0;
               state_in      = llwa_pkg::ST_SCAN;
            end
         end
         llwa_pkg::ST_SCAN: begin
            if (dat_ff == '0 || mem_rdata < best_ff) begin
               best_in     = mem_rdata;
               best_idx_in = dat_ff;
            end
            if (iss_ff < active_cnt) begin
               mem_ctl.rd_en = 1'b1;
               iss_in        = iss_ff + CNT_W'(1);
            end
            dat_in = dat_ff + IDX_W'(1);
            if (CNT_W'(dat_ff) + CNT_W'(1) == active_cnt) begin
               state_in = llwa_pkg::ST_ADD;
            end
         end
         llwa_pkg::ST_ADD: begin
            if (out_free) begin
               mem_ctl.wr_en = 1'b1;
               stat.res_load = 1'b1;
               state_in      = llwa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = llwa_pkg::ST_IDLE;
         end
      endcase
   end

   assign res_idx    = best_idx_ff;
   assign res_start  = best_ff;

endmodule
`default_nettype wire

@@ sv/least_loaded_worker_assigner.sv @@
// least_loaded_worker_assigner: assigns each job to the worker that frees up first.
// Accepts one request at a time: req_tready is high only while idle, so a new request
// waits until the one-read-per-cycle scan of the free-time memory and the update,
// which waits for a free output slot, are through. Reset: a clearing pass zeroes the
// memory with req_tready low; csr writes are taken throughout. Depends on llwa_pkg.
`default_nettype none
module least_loaded_worker_assigner #(
   parameter int MAX_WORKERS = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [31:0]  req_tdata,   // [31:0] job_duration
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,   // [5:0] worker_index, [68:6] start_time, [71:69] zero
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [7:0]   csr_data     // [6:0] worker_count
);

   localparam int IDX_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int CNT_W   = $clog2(MAX_WORKERS + 1);
   localparam int CW      = (CNT_W > llwa_pkg::CSR_W) ? CNT_W : llwa_pkg::CSR_W;
   localparam int RST_CNT = (MAX_WORKERS < llwa_pkg::CSR_RST) ? MAX_WORKERS : llwa_pkg::CSR_RST;

   logic [CNT_W-1:0]                active_ff, active_in;
   logic [CW-1:0]                   csr_ext;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [llwa_pkg::OIDX_W-1:0]     rsp_idx_ff;
   logic [llwa_pkg::TIME_W-1:0]     rsp_start_ff;
   logic                            out_free;
   llwa_pkg::llwa_mem_ctl_type      mem_ctl;
   llwa_pkg::llwa_stat_type         stat;
   logic [IDX_W-1:0]                mem_waddr, mem_raddr, res_idx;
   logic [llwa_pkg::TIME_W-1:0]     mem_wdata, mem_rdata, res_start;
   logic [IDX_W+llwa_pkg::OIDX_W-1:0] res_idx_ext;

   assign csr_ready = 1'b1;
   assign csr_ext   = CW'(csr_data[llwa_pkg::CSR_W-1:0]);

   always_comb begin
      if (csr_ext == '0) begin
         active_in = CNT_W'(1);
      end else if (csr_ext > CW'(MAX_WORKERS)) begin
         active_in = CNT_W'(MAX_WORKERS);
      end else begin
         active_in = csr_ext[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= CNT_W'(RST_CNT);
      end else if (csr_valid) begin
         active_ff <= active_in;
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = stat.res_load || (rsp_valid_ff && !rsp_tready);
   assign res_idx_ext  = {{llwa_pkg::OIDX_W{1'b0}}, res_idx};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.res_load) begin
         rsp_idx_ff   <= res_idx_ext[llwa_pkg::OIDX_W-1:0];
         rsp_start_ff <= res_start;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_start_ff, rsp_idx_ff};

   llwa_ctrl #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_dur    (req_tdata),
      .active_cnt (active_ff),
      .out_free   (out_free),
      .mem_ctl    (mem_ctl),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata),
      .stat       (stat),
      .res_idx    (res_idx),
      .res_start  (res_start)
   );

   llwa_time_mem #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   a_load_writes: assert property (@(posedge clock) disable iff (reset)
      stat.res_load |-> mem_ctl.wr_en)
      else $error("result issued without free-time update");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> stat.state == llwa_pkg::ST_SCAN && !req_tready)
      else $error("accepted request did not start a scan");

   a_idx_active: assert property (@(posedge clock) disable iff (reset)
      stat.res_load |-> CNT_W'(res_idx) < active_ff)
      else $error("chosen worker outside active range");

   a_no_decrease: assert property (@(posedge clock) disable iff (reset)
      stat.res_load |-> mem_wdata >= res_start)
      else $error("free time decreased on update");

endmodule
`default_nettype wire
